@@ rtl/bcci_pkg.sv @@
// ----------------------------------------------------------------------------
// bcci_pkg
// Shared widths, register codes and beat sideband types for the bilinear
// corner colour interpolation core.
// ----------------------------------------------------------------------------
package bcci_pkg;

    localparam int WEIGHT_FRAC_BITS_DEF = 16;
    localparam int QUO_EXTRA_BITS       = 21;

    localparam int COORD_W     = 16;
    localparam int SIZE_W      = 16;
    localparam int COLOR_W     = 32;
    localparam int CHAN_W      = 8;
    localparam int NUM_CORNERS = 4;
    localparam int NUM_CHANS   = 4;
    localparam int EDGE_W      = 18;
    localparam int PROD_W      = 2 * EDGE_W;
    localparam int AREA_W      = 2 * SIZE_W;
    localparam int DIV_W       = AREA_W + 3;
    localparam int HEAD_W      = 17;
    localparam int CFG_IDX_W   = 3;

    localparam logic [SIZE_W-1:0]  RECT_SIZE_RST = SIZE_W'(16);
    localparam logic [COLOR_W-1:0] COLOR_RST     = '1;
    localparam logic [CHAN_W-1:0]  CHAN_MAX      = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_WIDTH   = 3'd0,
        CFG_RECT_HEIGHT  = 3'd1,
        CFG_COLOR_LT     = 3'd2,
        CFG_COLOR_RT     = 3'd3,
        CFG_COLOR_LB     = 3'd4,
        CFG_COLOR_RB     = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic                       err;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } side_t;

    typedef struct packed {
        logic neg;
        logic ovf;
    } lane_flag_t;

endpackage

@@ rtl/bilinear_corner_color_interp_core.sv @@
// ----------------------------------------------------------------------------
// bilinear_corner_color_interp_core
// Blends four corner RGBA colours at a vertex position over a rectangle
// centred on the origin, with exact rounded bilinear weights.
//
//   channel  direction  signals
//   -------  ---------  ----------------------------------------------------
//   in       sink       in_valid, in_stall, pos_x, pos_y
//   out      source     out_valid, out_stall, out_x, out_y, red, green,
//                       blue, alpha, size_error
//   cfg      sink       cfg_we, cfg_index, cfg_data
//
// One beat per cycle in and out while the result is not stalled. The weight
// divider, one quotient bit per stage, sets the pipeline depth.
// Reset is asynchronous and clears all valid bits and the size and colour registers.
// A stalled result holds the whole pipeline; in_stall then rises in the
// same cycle, and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module bilinear_corner_color_interp_core #(
    parameter int WEIGHT_FRAC_BITS = bcci_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bcci_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcci_pkg::COLOR_W-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [bcci_pkg::COORD_W-1:0] pos_x,
    input  logic signed [bcci_pkg::COORD_W-1:0] pos_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [bcci_pkg::COORD_W-1:0] out_x,
    output logic signed [bcci_pkg::COORD_W-1:0] out_y,
    output logic [bcci_pkg::CHAN_W-1:0]         red,
    output logic [bcci_pkg::CHAN_W-1:0]         green,
    output logic [bcci_pkg::CHAN_W-1:0]         blue,
    output logic [bcci_pkg::CHAN_W-1:0]         alpha,
    output logic                                size_error
);
    import bcci_pkg::*;

    localparam int QW     = WEIGHT_FRAC_BITS + QUO_EXTRA_BITS;
    localparam int MW     = QW + HEAD_W;
    localparam int NUM_SH = WEIGHT_FRAC_BITS + 1;
    localparam int WQ_W   = QW + 1;
    localparam int MUL_W  = WQ_W + CHAN_W + 1;
    localparam int ACC_W  = MUL_W + 2;

    localparam logic signed [MW:0]    ONE_S      = (MW+1)'(1);
    localparam logic [QW-1:0]         WEIGHT_LIM = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        ACC_W'(1) <<< (WEIGHT_FRAC_BITS - 1);

    // configuration
    logic [SIZE_W-1:0]  rect_width_reg;
    logic [SIZE_W-1:0]  rect_height_reg;
    logic [COLOR_W-1:0] color_reg [NUM_CORNERS];
    logic [AREA_W-1:0]  area_reg;
    logic [DIV_W-1:0]   divisor;
    logic signed [MW:0] den4_s;
    logic signed [MW:0] div2_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_width_reg  <= RECT_SIZE_RST;
            rect_height_reg <= RECT_SIZE_RST;
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                color_reg[i] <= COLOR_RST;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_RECT_WIDTH:  rect_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_RECT_HEIGHT: rect_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_COLOR_LT:    color_reg[0]    <= cfg_data;
                CFG_COLOR_RT:    color_reg[1]    <= cfg_data;
                CFG_COLOR_LB:    color_reg[2]    <= cfg_data;
                CFG_COLOR_RB:    color_reg[3]    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg <= rect_width_reg * rect_height_reg;
    end

    assign divisor = {area_reg, 3'b000};
    assign den4_s  = signed'((MW+1)'({area_reg, 2'b00}));
    assign div2_s  = signed'((MW+1)'({area_reg, 3'b000}));

    // flow control
    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // stage 1: edge distances
    logic                      s1_valid_reg;
    side_t                     s1_side_reg;
    logic signed [EDGE_W-1:0]  s1_a_reg;
    logic signed [EDGE_W-1:0]  s1_b_reg;
    logic signed [EDGE_W-1:0]  s1_c_reg;
    logic signed [EDGE_W-1:0]  s1_d_reg;
    logic signed [EDGE_W-1:0]  w_s;
    logic signed [EDGE_W-1:0]  h_s;
    logic signed [EDGE_W-1:0]  x2_s;
    logic signed [EDGE_W-1:0]  y2_s;

    assign w_s  = signed'({2'b00, rect_width_reg});
    assign h_s  = signed'({2'b00, rect_height_reg});
    assign x2_s = signed'({pos_x[COORD_W-1], pos_x, 1'b0});
    assign y2_s = signed'({pos_y[COORD_W-1], pos_y, 1'b0});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg.err <= (rect_width_reg == '0) || (rect_height_reg == '0);
            s1_side_reg.x   <= pos_x;
            s1_side_reg.y   <= pos_y;
            s1_a_reg        <= w_s - x2_s;
            s1_b_reg        <= w_s + x2_s;
            s1_c_reg        <= h_s + y2_s;
            s1_d_reg        <= h_s - y2_s;
        end
    end

    // stage 2: weight numerators
    logic                      s2_valid_reg;
    side_t                     s2_side_reg;
    logic signed [PROD_W-1:0]  s2_num_reg [NUM_CORNERS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_side_reg   <= s1_side_reg;
            s2_num_reg[0] <= PROD_W'(s1_a_reg) * PROD_W'(s1_c_reg);
            s2_num_reg[1] <= PROD_W'(s1_b_reg) * PROD_W'(s1_c_reg);
            s2_num_reg[2] <= PROD_W'(s1_a_reg) * PROD_W'(s1_d_reg);
            s2_num_reg[3] <= PROD_W'(s1_b_reg) * PROD_W'(s1_d_reg);
        end
    end

    // stage 3: rounded dividend magnitude and sign
    logic                      s3_valid_reg;
    side_t                     s3_side_reg;
    logic [MW-1:0]             s3_mag_reg [NUM_CORNERS];
    logic [NUM_CORNERS-1:0]    s3_neg_reg;
    logic signed [MW:0]        n_s [NUM_CORNERS];
    logic signed [MW:0]        m_s [NUM_CORNERS];

    always_comb
    begin
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            n_s[i] = ((MW+1)'(s2_num_reg[i]) <<< NUM_SH) + den4_s;
            m_s[i] = n_s[i][MW] ? (div2_s - n_s[i] - ONE_S) : n_s[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg <= s2_side_reg;
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                s3_mag_reg[i] <= m_s[i][MW-1:0];
                s3_neg_reg[i] <= n_s[i][MW];
            end
        end
    end

    // stage 4: divider head, quotient range check
    logic                                          s4_valid_reg;
    side_t                                         s4_side_reg;
    lane_flag_t [NUM_CORNERS-1:0]                  s4_flag_reg;
    logic [NUM_CORNERS-1:0][DIV_W-1:0]             s4_rem_reg;
    logic [NUM_CORNERS-1:0][QW-1:0]                s4_quo_reg;
    logic [NUM_CORNERS-1:0][DIV_W-1:0]             head;

    always_comb
    begin
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            head[i] = DIV_W'(s3_mag_reg[i][MW-1:QW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg <= s3_side_reg;
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                s4_flag_reg[i].neg <= s3_neg_reg[i];
                s4_flag_reg[i].ovf <= head[i] >= divisor;
                s4_rem_reg[i]      <= head[i];
                s4_quo_reg[i]      <= s3_mag_reg[i][QW-1:0];
            end
        end
    end

    // divider stages
    logic                                  dv_valid [QW];
    side_t                                 dv_side  [QW];
    lane_flag_t [NUM_CORNERS-1:0]          dv_flag  [QW];
    logic [NUM_CORNERS-1:0][DIV_W-1:0]     dv_rem   [QW];
    logic [NUM_CORNERS-1:0][QW-1:0]        dv_quo   [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        if (k == 0)
        begin : g_first
            bcci_div_step #(.QW(QW)) u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .divisor   (divisor),
                .valid_in  (s4_valid_reg),
                .side_in   (s4_side_reg),
                .flag_in   (s4_flag_reg),
                .rem_in    (s4_rem_reg),
                .quo_in    (s4_quo_reg),
                .valid_out (dv_valid[k]),
                .side_out  (dv_side[k]),
                .flag_out  (dv_flag[k]),
                .rem_out   (dv_rem[k]),
                .quo_out   (dv_quo[k])
            );
        end
        else
        begin : g_next
            bcci_div_step #(.QW(QW)) u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .divisor   (divisor),
                .valid_in  (dv_valid[k-1]),
                .side_in   (dv_side[k-1]),
                .flag_in   (dv_flag[k-1]),
                .rem_in    (dv_rem[k-1]),
                .quo_in    (dv_quo[k-1]),
                .valid_out (dv_valid[k]),
                .side_out  (dv_side[k]),
                .flag_out  (dv_flag[k]),
                .rem_out   (dv_rem[k]),
                .quo_out   (dv_quo[k])
            );
        end
    end

    // weight stage: clamp and apply sign
    logic                      sw_valid_reg;
    side_t                     sw_side_reg;
    logic signed [WQ_W-1:0]    sw_wq_reg [NUM_CORNERS];
    logic [QW-1:0]             wmag [NUM_CORNERS];
    logic signed [WQ_W-1:0]    wpos [NUM_CORNERS];

    always_comb
    begin
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            if (dv_flag[QW-1][i].ovf ||
                (dv_quo[QW-1][i][QW-1] && (|dv_quo[QW-1][i][QW-2:0])))
            begin
                wmag[i] = WEIGHT_LIM;
            end
            else
            begin
                wmag[i] = dv_quo[QW-1][i];
            end
            wpos[i] = signed'({1'b0, wmag[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sw_side_reg <= dv_side[QW-1];
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                sw_wq_reg[i] <= dv_flag[QW-1][i].neg ? -wpos[i] : wpos[i];
            end
        end
    end

    // product stage: colour times weight
    logic                      sp_valid_reg;
    side_t                     sp_side_reg;
    logic signed [MUL_W-1:0]   sp_prod_reg [NUM_CHANS][NUM_CORNERS];
    logic signed [CHAN_W:0]    col_s [NUM_CHANS][NUM_CORNERS];

    always_comb
    begin
        for (int ch = 0; ch < NUM_CHANS; ch++)
        begin
            for (int i = 0; i < NUM_CORNERS; i++)
            begin
                col_s[ch][i] = signed'({1'b0,
                    color_reg[i][CHAN_W*(NUM_CHANS-1-ch) +: CHAN_W]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp_side_reg <= sw_side_reg;
            for (int ch = 0; ch < NUM_CHANS; ch++)
            begin
                for (int i = 0; i < NUM_CORNERS; i++)
                begin
                    sp_prod_reg[ch][i] <= MUL_W'(col_s[ch][i]) * MUL_W'(sw_wq_reg[i]);
                end
            end
        end
    end

    // sum stage
    logic                      ss_valid_reg;
    side_t                     ss_side_reg;
    logic signed [ACC_W-1:0]   ss_acc_reg [NUM_CHANS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ss_side_reg <= sp_side_reg;
            for (int ch = 0; ch < NUM_CHANS; ch++)
            begin
                ss_acc_reg[ch] <= ACC_W'(sp_prod_reg[ch][0]) + ACC_W'(sp_prod_reg[ch][1])
                                + ACC_W'(sp_prod_reg[ch][2]) + ACC_W'(sp_prod_reg[ch][3]);
            end
        end
    end

    // output stage: round, saturate, zero on size error
    side_t                     out_side_reg;
    logic [CHAN_W-1:0]         out_chan_reg [NUM_CHANS];
    logic signed [ACC_W-1:0]   rnd [NUM_CHANS];
    logic [CHAN_W-1:0]         chan_next [NUM_CHANS];

    always_comb
    begin
        for (int ch = 0; ch < NUM_CHANS; ch++)
        begin
            rnd[ch] = ss_acc_reg[ch] + ROUND_HALF;
            if (ss_side_reg.err || rnd[ch][ACC_W-1])
            begin
                chan_next[ch] = '0;
            end
            else if (|rnd[ch][ACC_W-2:WEIGHT_FRAC_BITS+CHAN_W])
            begin
                chan_next[ch] = CHAN_MAX;
            end
            else
            begin
                chan_next[ch] = rnd[ch][WEIGHT_FRAC_BITS +: CHAN_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_side_reg <= ss_side_reg;
            for (int ch = 0; ch < NUM_CHANS; ch++)
            begin
                out_chan_reg[ch] <= chan_next[ch];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            sw_valid_reg  <= 1'b0;
            sp_valid_reg  <= 1'b0;
            ss_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            sw_valid_reg  <= dv_valid[QW-1];
            sp_valid_reg  <= sw_valid_reg;
            ss_valid_reg  <= sp_valid_reg;
            out_valid_reg <= ss_valid_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = out_side_reg.x;
    assign out_y      = out_side_reg.y;
    assign size_error = out_side_reg.err;
    assign red        = out_chan_reg[0];
    assign green      = out_chan_reg[1];
    assign blue       = out_chan_reg[2];
    assign alpha      = out_chan_reg[3];

endmodule

@@ rtl/bcci_div_step.sv @@
// ----------------------------------------------------------------------------
// bcci_div_step
// One registered restoring-division step for the four weight lanes: shift
// in one dividend bit, compare against the divisor, subtract, emit one
// quotient bit.
// ----------------------------------------------------------------------------
module bcci_div_step #(
    parameter int QW = bcci_pkg::WEIGHT_FRAC_BITS_DEF + bcci_pkg::QUO_EXTRA_BITS
) (
    input  logic                                                        clk,
    input  logic                                                        rst_n,
    input  logic                                                        en,
    input  logic [bcci_pkg::DIV_W-1:0]                                  divisor,
    input  logic                                                        valid_in,
    input  bcci_pkg::side_t                                             side_in,
    input  bcci_pkg::lane_flag_t [bcci_pkg::NUM_CORNERS-1:0]            flag_in,
    input  logic [bcci_pkg::NUM_CORNERS-1:0][bcci_pkg::DIV_W-1:0]       rem_in,
    input  logic [bcci_pkg::NUM_CORNERS-1:0][QW-1:0]                    quo_in,
    output logic                                                        valid_out,
    output bcci_pkg::side_t                                             side_out,
    output bcci_pkg::lane_flag_t [bcci_pkg::NUM_CORNERS-1:0]            flag_out,
    output logic [bcci_pkg::NUM_CORNERS-1:0][bcci_pkg::DIV_W-1:0]       rem_out,
    output logic [bcci_pkg::NUM_CORNERS-1:0][QW-1:0]                    quo_out
);
    import bcci_pkg::*;

    logic [NUM_CORNERS-1:0][DIV_W:0]   trial;
    logic [NUM_CORNERS-1:0][DIV_W:0]   diff;
    logic [NUM_CORNERS-1:0]            fits;
    logic [NUM_CORNERS-1:0][DIV_W-1:0] rem_next;
    logic [NUM_CORNERS-1:0][QW-1:0]    quo_next;

    always_comb
    begin
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            trial[i]    = {rem_in[i], quo_in[i][QW-1]};
            diff[i]     = trial[i] - {1'b0, divisor};
            fits[i]     = trial[i] >= {1'b0, divisor};
            rem_next[i] = fits[i] ? diff[i][DIV_W-1:0] : trial[i][DIV_W-1:0];
            quo_next[i] = {quo_in[i][QW-2:0], fits[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else if (en)
        begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_out <= side_in;
            flag_out <= flag_in;
            rem_out  <= rem_next;
            quo_out  <= quo_next;
        end
    end

endmodule

@@ rtl/bcci_checker.sv @@
// ----------------------------------------------------------------------------
// bcci_checker
// Port-level checks for the interpolation core: output hold under stall,
// stall coupling between the channels, zero colour on a size error.
// ----------------------------------------------------------------------------
module bcci_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [bcci_pkg::COORD_W-1:0] out_x,
    input logic signed [bcci_pkg::COORD_W-1:0] out_y,
    input logic [bcci_pkg::CHAN_W-1:0]         red,
    input logic [bcci_pkg::CHAN_W-1:0]         green,
    input logic [bcci_pkg::CHAN_W-1:0]         blue,
    input logic [bcci_pkg::CHAN_W-1:0]         alpha,
    input logic                                size_error
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(red) && $stable(green) && $stable(blue) && $stable(alpha)
            && $stable(size_error))
        else $error("output beat changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled output beat");

    a_stall_prop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output beat is stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && size_error |-> red == '0 && green == '0 && blue == '0
            && alpha == '0)
        else $error("nonzero colour on size error");

endmodule

bind bilinear_corner_color_interp_core bcci_checker u_bcci_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .size_error (size_error)
);

@@ verif/bilinear_corner_color_interp_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_corner_color_interp_core_test
// Self-checking bench for the corner colour blender. Vertex beats go in with
// random gaps while the result channel is stalled at random. A fixed-point
// predictor works out each blended colour from the current register settings.
// Every result beat is checked field by field, in order.
// Directed cases cover the reset settings, the corners, extrapolation, zero
// size, unmapped register writes and extreme sizes. Random phases then sweep
// the register settings.
// ----------------------------------------------------------------------------
module bilinear_corner_color_interp_core_test;

    import bcci_pkg::*;

    localparam int WFB          = WEIGHT_FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_ITEMS = 1150;
    localparam int DRAIN_CYCLES = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [CHAN_W-1:0]         red;
        logic [CHAN_W-1:0]         green;
        logic [CHAN_W-1:0]         blue;
        logic [CHAN_W-1:0]         alpha;
        logic                      err;
    } vertex_color_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [COLOR_W-1:0]        cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic signed [COORD_W-1:0] pos_x     = '0;
    logic signed [COORD_W-1:0] pos_y     = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic [CHAN_W-1:0]         red;
    logic [CHAN_W-1:0]         green;
    logic [CHAN_W-1:0]         blue;
    logic [CHAN_W-1:0]         alpha;
    logic                      size_error;

    logic [SIZE_W-1:0]  rect_w;
    logic [SIZE_W-1:0]  rect_h;
    logic [COLOR_W-1:0] corner_rgba [NUM_CORNERS];

    vertex_color_t pending_colors [$];
    int            mismatches    = 0;
    int            cycle_count   = 0;
    int            feed_idle_pct = 30;
    int            stall_left    = 0;
    int            flow_left     = 0;
    int            stall_roll;

    always #6 clk = ~clk;

    bilinear_corner_color_interp_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_x      (out_x),
        .out_y      (out_y),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .size_error (size_error)
    );

    // round n/d to nearest, ties toward plus infinity, d > 0
    function automatic longint round_ratio(input longint n, input longint d);
        longint nn;
        longint dd;
        longint q;
        nn = 2 * n + d;
        dd = 2 * d;
        q  = nn / dd;
        if (nn % dd != 0 && nn < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic vertex_color_t blend_at(input logic signed [COORD_W-1:0] x,
                                               input logic signed [COORD_W-1:0] y);
        vertex_color_t     res;
        longint            xl;
        longint            yl;
        longint            w;
        longint            h;
        longint            area4;
        longint            unit;
        longint            clip;
        longint            acc;
        longint            level;
        longint            num [NUM_CORNERS];
        longint            wt [NUM_CORNERS];
        logic [CHAN_W-1:0] chan [NUM_CHANS];
        res   = '0;
        res.x = x;
        res.y = y;
        xl    = longint'(x);
        yl    = longint'(y);
        w     = longint'(rect_w);
        h     = longint'(rect_h);
        if (w == 0 || h == 0)
        begin
            res.err = 1'b1;
            return res;
        end
        num[0] = (w - 2 * xl) * (h + 2 * yl);
        num[1] = (w + 2 * xl) * (h + 2 * yl);
        num[2] = (w - 2 * xl) * (h - 2 * yl);
        num[3] = (w + 2 * xl) * (h - 2 * yl);
        area4  = 4 * w * h;
        unit   = longint'(1) << WFB;
        clip   = longint'(1) << (WFB + 20);
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            wt[k] = round_ratio(num[k] * unit, area4);
            if (wt[k] > clip)
                wt[k] = clip;
            if (wt[k] < -clip)
                wt[k] = -clip;
        end
        for (int ch = 0; ch < NUM_CHANS; ch++)
        begin
            acc = 0;
            for (int k = 0; k < NUM_CORNERS; k++)
                acc += longint'(corner_rgba[k][COLOR_W-1-CHAN_W*ch -: CHAN_W]) * wt[k];
            level = round_ratio(acc, unit);
            if (level < 0)
                level = 0;
            if (level > 255)
                level = 255;
            chan[ch] = CHAN_W'(level);
        end
        res.red   = chan[0];
        res.green = chan[1];
        res.blue  = chan[2];
        res.alpha = chan[3];
        return res;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("time %0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        vertex_color_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("time %0t: timeout, %0d results outstanding",
                     $time, pending_colors.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        else if (rst_n && out_valid && !out_stall)
        begin
            if (pending_colors.size() == 0)
            begin
                $display("time %0t: unexpected result beat, expected none, actual x=%0d y=%0d",
                         $time, out_x, out_y);
                mismatches++;
            end
            else
            begin
                want = pending_colors.pop_front();
                check_field("out_x", $signed(want.x), $signed(out_x));
                check_field("out_y", $signed(want.y), $signed(out_y));
                check_field("red", want.red, red);
                check_field("green", want.green, green);
                check_field("blue", want.blue, blue);
                check_field("alpha", want.alpha, alpha);
                check_field("size_error", want.err, size_error);
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (flow_left > 0)
        begin
            flow_left--;
            out_stall <= 1'b0;
        end
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 10)
                flow_left = $urandom_range(60, 250);
            else
                flow_left = $urandom_range(0, 6);
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 80)
                stall_left = $urandom_range(1, 3);
            else if (stall_roll < 96)
                stall_left = $urandom_range(4, 12);
            else
                stall_left = $urandom_range(20, 40);
            out_stall <= 1'b0;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll >= feed_idle_pct)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RECT_WIDTH:  rect_w = data[SIZE_W-1:0];
            CFG_RECT_HEIGHT: rect_h = data[SIZE_W-1:0];
            CFG_COLOR_LT:    corner_rgba[0] = data;
            CFG_COLOR_RT:    corner_rgba[1] = data;
            CFG_COLOR_LB:    corner_rgba[2] = data;
            CFG_COLOR_RB:    corner_rgba[3] = data;
            default: ;
        endcase
    endtask

    // hold valid across back-to-back beats; lower it only for a gap
    task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x    <= x;
        pos_y    <= y;
        do
            @(posedge clk);
        while (in_stall);
        pending_colors.push_back(blend_at(x, y));
    endtask

    task automatic wait_all_colors();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_colors.size() != 0);
    endtask

    task automatic set_shape(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        write_reg(CFG_RECT_WIDTH, COLOR_W'(w));
        write_reg(CFG_RECT_HEIGHT, COLOR_W'(h));
    endtask

    task automatic set_corners(input logic [COLOR_W-1:0] lt, input logic [COLOR_W-1:0] rt,
                               input logic [COLOR_W-1:0] lb, input logic [COLOR_W-1:0] rb);
        write_reg(CFG_COLOR_LT, lt);
        write_reg(CFG_COLOR_RT, rt);
        write_reg(CFG_COLOR_LB, lb);
        write_reg(CFG_COLOR_RB, rb);
    endtask

    task automatic test_reset_values();
        send_vertex(16'sd0, 16'sd0);
        send_vertex(16'sd8, 16'sd8);
        send_vertex(-16'sd8, -16'sd8);
        send_vertex(-16'sd32768, 16'sd32767);
        send_vertex(16'sd32767, -16'sd32768);
        wait_all_colors();
    endtask

    task automatic test_corner_blend();
        set_shape(16'd96, 16'd40);
        set_corners(32'hFF00_0080, 32'h00FF_0040, 32'h0000_FFC0, 32'h1234_5600);
        send_vertex(-16'sd48, 16'sd20);
        send_vertex(16'sd48, 16'sd20);
        send_vertex(-16'sd48, -16'sd20);
        send_vertex(16'sd48, -16'sd20);
        send_vertex(16'sd0, 16'sd0);
        send_vertex(-16'sd24, 16'sd10);
        send_vertex(16'sd7, -16'sd3);
        send_vertex(16'sd200, 16'sd0);
        send_vertex(-16'sd200, -16'sd90);
        wait_all_colors();
    endtask

    task automatic test_zero_size();
        set_shape(16'd0, 16'd40);
        send_vertex(16'sd100, -16'sd100);
        send_vertex(-16'sd32768, -16'sd32768);
        wait_all_colors();
        set_shape(16'd96, 16'd0);
        send_vertex(16'sd5, 16'sd5);
        wait_all_colors();
        write_reg(CFG_RECT_WIDTH, 32'hFFFF_0000);
        send_vertex(16'sd32767, 16'sd32767);
        wait_all_colors();
    endtask

    task automatic test_unmapped_writes();
        set_shape(16'd16, 16'd16);
        set_corners('1, '1, '1, '1);
        write_reg(CFG_UNMAPPED_LO, '0);
        write_reg(CFG_UNMAPPED_HI, '0);
        send_vertex(16'sd0, 16'sd0);
        send_vertex(-16'sd8, 16'sd8);
        wait_all_colors();
    endtask

    task automatic test_extreme_sizes();
        set_shape('1, '1);
        set_corners(32'h80FF_0001, 32'h0180_FF00, 32'hFF01_8000, 32'h00FF_0180);
        send_vertex(16'sd32767, 16'sd32767);
        send_vertex(-16'sd32768, -16'sd32768);
        send_vertex(16'sd0, 16'sd0);
        wait_all_colors();
        set_shape(16'd1, 16'd1);
        send_vertex(16'sd0, 16'sd0);
        send_vertex(16'sd1, -16'sd1);
        wait_all_colors();
        set_shape('1, 16'd1);
        send_vertex(16'sd1000, 16'sd0);
        wait_all_colors();
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return '0;
        if (roll < 16)
            return '1;
        if (roll < 28)
            return SIZE_W'($urandom_range(1, 4));
        if (roll < 75)
            return SIZE_W'($urandom_range(2, 600));
        return SIZE_W'($urandom);
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        return COLOR_W'($urandom);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(input logic [SIZE_W-1:0] span);
        int half;
        int reach;
        int v;
        int roll;
        roll = $urandom_range(0, 99);
        if (span == 0 || roll < 10)
            return COORD_W'($urandom);
        half = int'(span) / 2;
        if (roll < 20)
            v = ($urandom_range(0, 1) == 0) ? half : -half;
        else
        begin
            reach = half + half / 4 + 1;
            v     = int'($urandom_range(0, 2 * reach)) - reach;
        end
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return COORD_W'(v);
    endfunction

    task automatic randomize_registers();
        write_reg(CFG_RECT_WIDTH, {16'($urandom), pick_size()});
        write_reg(CFG_RECT_HEIGHT, {16'($urandom), pick_size()});
        set_corners(pick_color(), pick_color(), pick_color(), pick_color());
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO,
                      COLOR_W'($urandom));
    endtask

    task automatic test_random_sweep();
        int sent;
        int phase;
        int phase_len;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            randomize_registers();
            case ($urandom_range(0, 3))
                0:       feed_idle_pct = 0;
                1:       feed_idle_pct = 10;
                2:       feed_idle_pct = 30;
                default: feed_idle_pct = 60;
            endcase
            phase_len = $urandom_range(30, 70);
            for (int n = 0; n < phase_len; n++)
            begin
                if (n == phase_len / 2 && phase % 3 == 1)
                    wait_all_colors();
                send_vertex(pick_coord(rect_w), pick_coord(rect_h));
                sent++;
            end
            wait_all_colors();
            phase++;
        end
    endtask

    initial
    begin
        rect_w = RECT_SIZE_RST;
        rect_h = RECT_SIZE_RST;
        for (int k = 0; k < NUM_CORNERS; k++)
            corner_rgba[k] = COLOR_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_corner_blend();
        test_zero_size();
        test_unmapped_writes();
        test_extreme_sizes();
        test_random_sweep();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_colors.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
